// File: sv/tcd_pkg.sv
// Shared types and constants for the textured column drawer.
`timescale 1ns / 1ps
`default_nettype none

package tcd_pkg;

  localparam int TEXTURE_DEPTH_DEF = 256;
  localparam int PLAIN_WRAP        = 128;
  localparam int FRAC_BITS         = 16;

  localparam logic [7:0] PLAIN_MASK = 8'(PLAIN_WRAP - 1);

  // Field widths fixed by the interface
  localparam int CMD_W   = 3;
  localparam int COL_W   = 12;
  localparam int ROW_W   = 11;
  localparam int FIX_W   = 32;
  localparam int MODE_W  = 2;
  localparam int IDX_W   = 16;
  localparam int BYTE_W  = 8;
  localparam int ADDR_W  = 23;
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 2;
  localparam int TINT_DEPTH = 65536;
  localparam int MAP_DEPTH  = 256;

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN = 3'd0,
    CMD_PIXEL = 3'd1,
    CMD_TEXEL = 3'd2,
    CMD_LIGHT = 3'd3,
    CMD_XLAT  = 3'd4,
    CMD_TINT  = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PIXEL,
    OP_TEXEL,
    OP_LIGHT,
    OP_XLAT,
    OP_TINT
  } op_kind_t;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_X     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_Y     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 2'd3;

  localparam int MODE_TRANSLUCENT_BIT = 0;
  localparam int MODE_TRANSLATED_BIT  = 1;

  // One word travelling down the lookup pipeline
  typedef struct packed {
    op_kind_t            kind;
    logic [IDX_W-1:0]    index;
    logic [BYTE_W-1:0]   value;
    logic [IDX_W-1:0]    quot;     // estimated table_index / TEXTURE_DEPTH
    logic [MODE_W-1:0]   mode;
    logic [ADDR_W-1:0]   address;
    logic [ROW_W-1:0]    row;
    logic                last;
    logic [BYTE_W-1:0]   under;
  } op_t;

endpackage

`default_nettype wire

// File: sv/textured_column_drawer_core.sv
// Top level of the textured column drawer.
// A next-pixel word passes the front register, s2 to s5 and the output register.
// Throughput: one command word per cycle; the texel, translation, light and tint
// memories each sit in their own pipeline stage, and the whole pipe holds while
// a finished pixel waits on pix_stall. Reset clears column state and the pipe;
// the four tables hold whatever was last written and have no reset.
`timescale 1ns / 1ps
`default_nettype none

module textured_column_drawer_core import tcd_pkg::*; #(
  parameter int TEXTURE_DEPTH = TEXTURE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    cmd_valid,
  output logic                    cmd_stall,
  input  logic [CMD_W-1:0]        command,
  input  logic [COL_W-1:0]        column,
  input  logic [ROW_W-1:0]        top_row,
  input  logic [ROW_W-1:0]        bottom_row,
  input  logic signed [FIX_W-1:0] texture_mid,
  input  logic signed [FIX_W-1:0] inverse_scale,
  input  logic [MODE_W-1:0]       draw_mode,
  input  logic [IDX_W-1:0]        table_index,
  input  logic [BYTE_W-1:0]       table_value,
  input  logic [BYTE_W-1:0]       under_pixel,
  output logic                    pix_valid,
  input  logic                    pix_stall,
  output logic [BYTE_W-1:0]       pixel_color,
  output logic [ADDR_W-1:0]       pixel_address,
  output logic [ROW_W-1:0]        pixel_row,
  output logic                    last_in_column
);

  logic                             adv;
  op_t                              s1;
  logic [$clog2(TEXTURE_DEPTH)-1:0] tex_index;

  assign cmd_stall = !adv;

  tcd_front #(.TEXTURE_DEPTH(TEXTURE_DEPTH)) u_front (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd_valid     (cmd_valid),
    .command       (command),
    .column        (column),
    .top_row       (top_row),
    .bottom_row    (bottom_row),
    .texture_mid   (texture_mid),
    .inverse_scale (inverse_scale),
    .draw_mode     (draw_mode),
    .table_index   (table_index),
    .table_value   (table_value),
    .under_pixel   (under_pixel),
    .op            (s1),
    .tex_index     (tex_index)
  );

  tcd_lookup #(.TEXTURE_DEPTH(TEXTURE_DEPTH)) u_lookup (
    .clk            (clk),
    .rst            (rst),
    .s1             (s1),
    .tex_index      (tex_index),
    .pix_stall      (pix_stall),
    .adv            (adv),
    .pix_valid      (pix_valid),
    .pixel_color    (pixel_color),
    .pixel_address  (pixel_address),
    .pixel_row      (pixel_row),
    .last_in_column (last_in_column)
  );

endmodule

`default_nettype wire

// File: sv/tcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/tcd_front.sv
// Command decode, column state, configuration registers and texel index.
`timescale 1ns / 1ps
`default_nettype none

module tcd_front import tcd_pkg::*; #(
  parameter int TEXTURE_DEPTH = TEXTURE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             adv,
  input  logic                             cfg_write,
  input  logic [CFG_IDX_W-1:0]             cfg_index,
  input  logic [CFG_W-1:0]                 cfg_data,
  input  logic                             cmd_valid,
  input  logic [CMD_W-1:0]                 command,
  input  logic [COL_W-1:0]                 column,
  input  logic [ROW_W-1:0]                 top_row,
  input  logic [ROW_W-1:0]                 bottom_row,
  input  logic signed [FIX_W-1:0]          texture_mid,
  input  logic signed [FIX_W-1:0]          inverse_scale,
  input  logic [MODE_W-1:0]                draw_mode,
  input  logic [IDX_W-1:0]                 table_index,
  input  logic [BYTE_W-1:0]                table_value,
  input  logic [BYTE_W-1:0]                under_pixel,
  output op_t                              op,
  output logic [$clog2(TEXTURE_DEPTH)-1:0] tex_index
);

  localparam int TEX_AW = $clog2(TEXTURE_DEPTH);
  localparam logic [16:0] RECIP = 17'(65536 / TEXTURE_DEPTH);
  localparam logic [10:0] DEPTH_V = 11'(TEXTURE_DEPTH);

  logic [ROW_W-1:0]  center_row;
  logic [COL_W-1:0]  window_x;
  logic [ROW_W-1:0]  window_y;
  logic [CFG_W-1:0]  screen_width;

  logic [FIX_W-1:0]  fraction;
  logic [FIX_W-1:0]  frac_step;
  logic [ADDR_W-1:0] cur_addr;
  logic [ROW_W-1:0]  cur_row;
  logic [ROW_W-1:0]  end_row;
  logic [MODE_W-1:0] active_mode;
  logic              active;

  logic [ROW_W:0]    diff;
  logic [FIX_W-1:0]  diff_ext;
  logic [FIX_W-1:0]  start_prod;
  logic [FIX_W-1:0]  start_frac;
  logic [ROW_W:0]    row_sum;
  logic [24:0]       base_prod;
  logic [24:0]       start_sum;
  logic [7:0]        ip_bits;
  logic [7:0]        raw_idx;
  logic [10:0]       wrapped;
  logic [32:0]       quot_prod;
  logic              at_end;
  op_t               op_next;

  // start fraction: texture_mid + (top_row - center_row) * step, mod 2^32
  assign diff       = {1'b0, top_row} - {1'b0, center_row};
  assign diff_ext   = {{(FIX_W-ROW_W-1){diff[ROW_W]}}, diff};
  assign start_prod = diff_ext * $unsigned(inverse_scale);
  assign start_frac = $unsigned(texture_mid) + start_prod;

  assign row_sum   = {1'b0, top_row} + {1'b0, window_y};
  assign base_prod = row_sum * screen_width;
  assign start_sum = base_prod + {13'd0, window_x} + {13'd0, column};

  // integer part of the fraction; plain modes wrap, translated keep 8 bits
  assign ip_bits = fraction[FRAC_BITS +: 8];
  assign raw_idx = active_mode[MODE_TRANSLATED_BIT] ? ip_bits : (ip_bits & PLAIN_MASK);
  assign wrapped = ({3'd0, raw_idx} >= DEPTH_V) ? ({3'd0, raw_idx} - DEPTH_V)
                                                : {3'd0, raw_idx};

  // reciprocal estimate, low by at most one; finished in the lookup stage
  assign quot_prod = table_index * RECIP;

  assign at_end = cur_row == end_row;

  always_comb begin
    op_next         = '0;
    op_next.kind    = OP_NONE;
    op_next.index   = table_index;
    op_next.value   = table_value;
    op_next.quot    = quot_prod[31:16];
    op_next.mode    = active_mode;
    op_next.address = cur_addr;
    op_next.row     = cur_row;
    op_next.last    = at_end;
    op_next.under   = under_pixel;
    if (cmd_valid) begin
      case (cmd_t'(command))
        CMD_PIXEL: op_next.kind = active ? OP_PIXEL : OP_NONE;
        CMD_TEXEL: op_next.kind = OP_TEXEL;
        CMD_LIGHT: op_next.kind = OP_LIGHT;
        CMD_XLAT:  op_next.kind = OP_XLAT;
        CMD_TINT:  op_next.kind = OP_TINT;
        default:   op_next.kind = OP_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      center_row   <= 11'd84;
      window_x     <= '0;
      window_y     <= '0;
      screen_width <= 13'd320;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CENTER_ROW:   center_row   <= cfg_data[ROW_W-1:0];
        REG_WINDOW_X:     window_x     <= cfg_data[COL_W-1:0];
        REG_WINDOW_Y:     window_y     <= cfg_data[ROW_W-1:0];
        REG_SCREEN_WIDTH: screen_width <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fraction    <= '0;
      frac_step   <= '0;
      cur_addr    <= '0;
      cur_row     <= '0;
      end_row     <= '0;
      active_mode <= '0;
      active      <= 1'b0;
      op.kind     <= OP_NONE;
    end else if (adv) begin
      op        <= op_next;
      tex_index <= wrapped[TEX_AW-1:0];
      if (cmd_valid) begin
        case (cmd_t'(command))
          CMD_BEGIN: begin
            fraction    <= start_frac;
            frac_step   <= $unsigned(inverse_scale);
            cur_addr    <= start_sum[ADDR_W-1:0];
            cur_row     <= top_row;
            end_row     <= bottom_row;
            active_mode <= draw_mode;
            active      <= bottom_row >= top_row;
          end
          CMD_PIXEL: begin
            if (active) begin
              if (at_end) begin
                active <= 1'b0;
              end else begin
                cur_row <= cur_row + 1'b1;
              end
              cur_addr <= cur_addr + {10'd0, screen_width};
              fraction <= fraction + frac_step;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/tcd_lookup.sv
// Table lookup pipeline: texel, translation, light and tint memories, output register.
`timescale 1ns / 1ps
`default_nettype none

module tcd_lookup import tcd_pkg::*; #(
  parameter int TEXTURE_DEPTH = TEXTURE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  op_t                              s1,
  input  logic [$clog2(TEXTURE_DEPTH)-1:0] tex_index,
  input  logic                             pix_stall,
  output logic                             adv,
  output logic                             pix_valid,
  output logic [BYTE_W-1:0]                pixel_color,
  output logic [ADDR_W-1:0]                pixel_address,
  output logic [ROW_W-1:0]                 pixel_row,
  output logic                             last_in_column
);

  localparam int TEX_AW = $clog2(TEXTURE_DEPTH);
  localparam logic [10:0] DEPTH_V = 11'(TEXTURE_DEPTH);

  op_t s2, s3, s4, s5;
  logic [BYTE_W-1:0] s3_texel;
  logic [BYTE_W-1:0] s5_color;

  logic [BYTE_W-1:0] tex_rdata, xlat_rdata, light_rdata, tint_rdata;
  logic [BYTE_W-1:0] light_raddr;

  logic [26:0]       rem_prod;
  logic [IDX_W-1:0]  rem;
  logic [IDX_W-1:0]  rem_fix;

  // whole pipe moves unless a finished word is held at the output
  assign adv = !pix_valid || !pix_stall;

  // table_index mod depth: the estimate leaves a remainder below twice the depth
  assign rem_prod = s1.quot * DEPTH_V;
  assign rem      = s1.index - rem_prod[IDX_W-1:0];
  assign rem_fix  = (rem >= {5'd0, DEPTH_V}) ? (rem - {5'd0, DEPTH_V}) : rem;

  // Each table is written in the stage where it is read, so order is kept.
  tcd_ram #(.WIDTH(BYTE_W), .DEPTH(TEXTURE_DEPTH)) u_tex_ram (
    .clk   (clk),
    .we    (adv && s1.kind == OP_TEXEL),
    .waddr (rem_fix[TEX_AW-1:0]),
    .wdata (s1.value),
    .re    (adv),
    .raddr (tex_index),
    .rdata (tex_rdata)
  );

  tcd_ram #(.WIDTH(BYTE_W), .DEPTH(MAP_DEPTH)) u_xlat_ram (
    .clk   (clk),
    .we    (adv && s2.kind == OP_XLAT),
    .waddr (s2.index[BYTE_W-1:0]),
    .wdata (s2.value),
    .re    (adv),
    .raddr (tex_rdata),
    .rdata (xlat_rdata)
  );

  assign light_raddr = s3.mode[MODE_TRANSLATED_BIT] ? xlat_rdata : s3_texel;

  tcd_ram #(.WIDTH(BYTE_W), .DEPTH(MAP_DEPTH)) u_light_ram (
    .clk   (clk),
    .we    (adv && s3.kind == OP_LIGHT),
    .waddr (s3.index[BYTE_W-1:0]),
    .wdata (s3.value),
    .re    (adv),
    .raddr (light_raddr),
    .rdata (light_rdata)
  );

  tcd_ram #(.WIDTH(BYTE_W), .DEPTH(TINT_DEPTH)) u_tint_ram (
    .clk   (clk),
    .we    (adv && s4.kind == OP_TINT),
    .waddr (s4.index),
    .wdata (s4.value),
    .re    (adv),
    .raddr ({s4.under, light_rdata}),
    .rdata (tint_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.kind   <= OP_NONE;
      s3.kind   <= OP_NONE;
      s4.kind   <= OP_NONE;
      s5.kind   <= OP_NONE;
      pix_valid <= 1'b0;
    end else if (adv) begin
      s2             <= s1;
      s3             <= s2;
      s3_texel       <= tex_rdata;
      s4             <= s3;
      s5             <= s4;
      s5_color       <= light_rdata;
      pix_valid      <= s5.kind == OP_PIXEL;
      pixel_color    <= s5.mode[MODE_TRANSLUCENT_BIT] ? tint_rdata : s5_color;
      pixel_address  <= s5.address;
      pixel_row      <= s5.row;
      last_in_column <= s5.last;
    end
  end

endmodule

`default_nettype wire

// File: sv/tcd_checker.sv
// Port-level checks for the textured column drawer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tcd_checker import tcd_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              cmd_stall,
  input logic              pix_valid,
  input logic              pix_stall,
  input logic [BYTE_W-1:0] pixel_color,
  input logic [ADDR_W-1:0] pixel_address,
  input logic [ROW_W-1:0]  pixel_row,
  input logic              last_in_column
);

  // held pixel word stays put
  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_stall |=> pix_valid && $stable(pixel_color) &&
      $stable(pixel_address) && $stable(pixel_row) && $stable(last_in_column))
    else $error("pixel word changed while stalled");

  // input side only backs up when the output register is full and held
  a_stall_cause: assert property (@(posedge clk)
    cmd_stall |-> pix_valid && pix_stall)
    else $error("command stall without a held pixel");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !pix_valid)
    else $error("pixel valid right after reset");

endmodule

bind textured_column_drawer_core tcd_checker u_tcd_checker (.*);

`default_nettype wire

// File: tb/textured_column_drawer_core_tb.sv
// Self-checking testbench for the textured column drawer core.
`timescale 1ns / 1ps

module textured_column_drawer_core_tb;
  import tcd_pkg::*;

  localparam int STALL_LIMIT  = 4000;  // cycles with no accepted word before giving up
  localparam int DRAIN_CYCLES = 12;    // covers the pipe depth, with margin
  localparam int PHASE_WORDS  = 130;

  // commands the block must drop
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef struct {
    logic [CMD_W-1:0]  command;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  top_row;
    logic [ROW_W-1:0]  bottom_row;
    logic [FIX_W-1:0]  texture_mid;
    logic [FIX_W-1:0]  inverse_scale;
    logic [MODE_W-1:0] draw_mode;
    logic [IDX_W-1:0]  table_index;
    logic [BYTE_W-1:0] table_value;
    logic [BYTE_W-1:0] under_pixel;
  } cmd_word_t;

  typedef struct {
    logic [BYTE_W-1:0] color;
    logic [ADDR_W-1:0] address;
    logic [ROW_W-1:0]  row;
    logic              last;
  } pixel_t;

  class column_scoreboard;
    logic [ROW_W-1:0]  center_row;
    logic [COL_W-1:0]  window_x;
    logic [ROW_W-1:0]  window_y;
    logic [CFG_W-1:0]  screen_width;

    logic [BYTE_W-1:0] texels [TEXTURE_DEPTH_DEF];
    logic [BYTE_W-1:0] light  [MAP_DEPTH];
    logic [BYTE_W-1:0] xlat   [MAP_DEPTH];
    logic [BYTE_W-1:0] tint   [TINT_DEPTH];
    bit                texel_known [TEXTURE_DEPTH_DEF];
    bit                light_known [MAP_DEPTH];
    bit                xlat_known  [MAP_DEPTH];
    bit                tint_known  [TINT_DEPTH];

    logic [FIX_W-1:0]  frac;
    logic [FIX_W-1:0]  step;
    logic [ADDR_W-1:0] addr;
    logic [ROW_W-1:0]  row;
    logic [ROW_W-1:0]  end_row;
    logic [MODE_W-1:0] mode;
    bit                active;

    pixel_t pending_pixels[$];
    int     errors;
    int     checked;

    function new();
      center_row   = 11'd84;
      window_x     = '0;
      window_y     = '0;
      screen_width = 13'd320;
      frac = '0; step = '0; addr = '0; row = '0; end_row = '0; mode = '0;
      active = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_CENTER_ROW:   center_row   = data[ROW_W-1:0];
        REG_WINDOW_X:     window_x     = data[COL_W-1:0];
        REG_WINDOW_Y:     window_y     = data[ROW_W-1:0];
        REG_SCREEN_WIDTH: screen_width = data;
        default: ;
      endcase
    endfunction

    // texel entry read by the next pixel
    function logic [7:0] texel_slot();
      logic [7:0] idx;
      idx = frac[FRAC_BITS +: 8];
      if (!mode[MODE_TRANSLATED_BIT]) idx = idx & PLAIN_MASK;
      return idx;
    endfunction

    // colormap output of the next pixel, before any tint blend
    function logic [BYTE_W-1:0] base_color();
      logic [7:0] texel;
      texel = texels[texel_slot()];
      if (mode[MODE_TRANSLATED_BIT]) texel = xlat[texel];
      return light[texel];
    endfunction

    // returns 1 when the word does something
    function bit note_word(cmd_word_t w);
      logic [31:0] diff;
      logic [31:0] prod;
      logic [63:0] lin;
      pixel_t      px;
      case (w.command)
        CMD_BEGIN: begin
          diff = 32'(w.top_row) - 32'(center_row);
          prod = diff * w.inverse_scale;
          frac = w.texture_mid + prod;
          step = w.inverse_scale;
          lin = (64'(w.top_row) + 64'(window_y)) * 64'(screen_width)
                + 64'(window_x) + 64'(w.column);
          addr = lin[ADDR_W-1:0];
          row = w.top_row;
          end_row = w.bottom_row;
          mode = w.draw_mode;
          active = w.bottom_row >= w.top_row;
          return 1;
        end
        CMD_PIXEL: begin
          if (!active) return 0;
          px.color = base_color();
          if (mode[MODE_TRANSLUCENT_BIT]) px.color = tint[{w.under_pixel, px.color}];
          px.address = addr;
          px.row = row;
          px.last = (row == end_row);
          pending_pixels.push_back(px);
          if (px.last) active = 0;
          else row = row + 1'b1;
          addr = addr + ADDR_W'(screen_width);
          frac = frac + step;
          return 1;
        end
        CMD_TEXEL: begin
          texels[w.table_index[7:0]] = w.table_value;
          texel_known[w.table_index[7:0]] = 1;
          return 1;
        end
        CMD_LIGHT: begin
          light[w.table_index[7:0]] = w.table_value;
          light_known[w.table_index[7:0]] = 1;
          return 1;
        end
        CMD_XLAT: begin
          xlat[w.table_index[7:0]] = w.table_value;
          xlat_known[w.table_index[7:0]] = 1;
          return 1;
        end
        CMD_TINT: begin
          tint[w.table_index] = w.table_value;
          tint_known[w.table_index] = 1;
          return 1;
        end
        default: return 0;
      endcase
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t exp_px;
      if (pending_pixels.size() == 0) begin
        $display("%0t: pixel with none expected: color %h address %h row %0d last %b",
                 $time, got.color, got.address, got.row, got.last);
        errors++;
        return;
      end
      exp_px = pending_pixels.pop_front();
      checked++;
      if (got.color !== exp_px.color) begin
        $display("%0t: pixel_color expected %h actual %h", $time, exp_px.color, got.color);
        errors++;
      end
      if (got.address !== exp_px.address) begin
        $display("%0t: pixel_address expected %h actual %h", $time, exp_px.address,
                 got.address);
        errors++;
      end
      if (got.row !== exp_px.row) begin
        $display("%0t: pixel_row expected %0d actual %0d", $time, exp_px.row, got.row);
        errors++;
      end
      if (got.last !== exp_px.last) begin
        $display("%0t: last_in_column expected %b actual %b", $time, exp_px.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 cmd_valid = 1'b0;
  logic                 cmd_stall;
  logic [CMD_W-1:0]     command = '0;
  logic [COL_W-1:0]     column = '0;
  logic [ROW_W-1:0]     top_row = '0;
  logic [ROW_W-1:0]     bottom_row = '0;
  logic [FIX_W-1:0]     texture_mid = '0;
  logic [FIX_W-1:0]     inverse_scale = '0;
  logic [MODE_W-1:0]    draw_mode = '0;
  logic [IDX_W-1:0]     table_index = '0;
  logic [BYTE_W-1:0]    table_value = '0;
  logic [BYTE_W-1:0]    under_pixel = '0;
  logic                 pix_valid;
  logic                 pix_stall = 1'b0;
  logic [BYTE_W-1:0]    pixel_color;
  logic [ADDR_W-1:0]    pixel_address;
  logic [ROW_W-1:0]     pixel_row;
  logic                 last_in_column;

  textured_column_drawer_core dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .command(command), .column(column), .top_row(top_row), .bottom_row(bottom_row),
    .texture_mid(texture_mid), .inverse_scale(inverse_scale), .draw_mode(draw_mode),
    .table_index(table_index), .table_value(table_value), .under_pixel(under_pixel),
    .pix_valid(pix_valid), .pix_stall(pix_stall),
    .pixel_color(pixel_color), .pixel_address(pixel_address),
    .pixel_row(pixel_row), .last_in_column(last_in_column)
  );

  always #5 clk = ~clk;

  column_scoreboard sb;
  int idle_pct = 0;
  int stall_pct = 0;
  int idle_cycles = 0;
  int words_sent = 0;
  int settings_used = 0;

  always @(posedge clk) begin : pixel_monitor
    pixel_t got;
    if (rst) begin
      idle_cycles <= 0;
      pix_stall <= 1'b0;
    end else begin
      if (pix_valid && !pix_stall) begin
        got = '{pixel_color, pixel_address, pixel_row, last_in_column};
        sb.check_pixel(got);
      end
      if ((cmd_valid && !cmd_stall) || (pix_valid && !pix_stall) || cfg_write)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      pix_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin : watchdog
    wait (!rst);
    wait (idle_cycles >= STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  function automatic cmd_word_t random_word();
    cmd_word_t w;
    w.command       = 3'($urandom);
    w.column        = 12'($urandom);
    w.top_row       = 11'($urandom);
    w.bottom_row    = 11'($urandom);
    w.texture_mid   = $urandom;
    w.inverse_scale = $urandom;
    w.draw_mode     = 2'($urandom);
    w.table_index   = 16'($urandom);
    w.table_value   = 8'($urandom);
    w.under_pixel   = 8'($urandom);
    return w;
  endfunction

  // valid stays high from one word to the next unless a gap is drawn
  task automatic send_word(input cmd_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid     <= 1'b1;
    command       <= w.command;
    column        <= w.column;
    top_row       <= w.top_row;
    bottom_row    <= w.bottom_row;
    texture_mid   <= w.texture_mid;
    inverse_scale <= w.inverse_scale;
    draw_mode     <= w.draw_mode;
    table_index   <= w.table_index;
    table_value   <= w.table_value;
    under_pixel   <= w.under_pixel;
    do @(posedge clk); while (cmd_stall);
    if (sb.note_word(w)) words_sent++;
  endtask

  task automatic send_table(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                            input logic [BYTE_W-1:0] value);
    cmd_word_t w;
    w = random_word();
    w.command = cmd;
    w.table_index = idx;
    w.table_value = value;
    send_word(w);
  endtask

  task automatic send_begin(input logic [MODE_W-1:0] mode, input logic [ROW_W-1:0] top,
                            input logic [ROW_W-1:0] bottom, input logic [FIX_W-1:0] mid,
                            input logic [FIX_W-1:0] stp, input logic [COL_W-1:0] col);
    cmd_word_t w;
    w = random_word();
    w.command = CMD_BEGIN;
    w.draw_mode = mode;
    w.top_row = top;
    w.bottom_row = bottom;
    w.texture_mid = mid;
    w.inverse_scale = stp;
    w.column = col;
    send_word(w);
  endtask

  // a drawn pixel must never hit a table entry that was never loaded
  task automatic send_pixel(input logic [BYTE_W-1:0] under);
    cmd_word_t         w;
    logic [7:0]        idx;
    logic [7:0]        texel;
    logic [BYTE_W-1:0] color;
    logic [IDX_W-1:0]  slot;
    if (sb.active) begin
      idx = sb.texel_slot();
      if (!sb.texel_known[idx]) send_table(CMD_TEXEL, {8'($urandom), idx}, 8'($urandom));
      texel = sb.texels[idx];
      if (sb.mode[MODE_TRANSLATED_BIT]) begin
        if (!sb.xlat_known[texel])
          send_table(CMD_XLAT, {8'($urandom), texel}, 8'($urandom));
        texel = sb.xlat[texel];
      end
      if (!sb.light_known[texel]) send_table(CMD_LIGHT, {8'($urandom), texel}, 8'($urandom));
      color = sb.light[texel];
      if (sb.mode[MODE_TRANSLUCENT_BIT]) begin
        slot = {under, color};
        if (!sb.tint_known[slot]) send_table(CMD_TINT, slot, 8'($urandom));
      end
    end
    w = random_word();
    w.command = CMD_PIXEL;
    w.under_pixel = under;
    send_word(w);
  endtask

  task automatic send_spare(input logic [CMD_W-1:0] cmd);
    cmd_word_t w;
    w = random_word();
    w.command = cmd;
    send_word(w);
  endtask

  task automatic settle();
    cmd_valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // four back-to-back register writes; only called with the pipe empty
  task automatic program_view(input logic [CFG_W-1:0] center, input logic [CFG_W-1:0] wx,
                              input logic [CFG_W-1:0] wy, input logic [CFG_W-1:0] sw);
    logic [CFG_W-1:0] vals [4];
    vals = '{center, wx, wy, sw};
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.write_reg(CFG_IDX_W'(i), vals[i]);
    end
    cfg_write <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic random_column();
    logic [ROW_W-1:0] top;
    logic [ROW_W-1:0] bottom;
    logic [FIX_W-1:0] stp;
    int height;
    int npix;
    top = 11'($urandom_range(0, 2047));
    height = ($urandom_range(9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
    bottom = (int'(top) + height > 2047) ? 11'd2047 : 11'(int'(top) + height);
    if ($urandom_range(1) == 0) stp = $urandom_range(0, 6 * 65536) - 32'd196608;
    else stp = $urandom;
    send_begin(2'($urandom), top, bottom, $urandom, stp, 12'($urandom));
    npix = int'(bottom) - int'(top) + 1;
    case ($urandom_range(9))
      0: npix = $urandom_range(0, npix - 1);       // abandoned by the next begin
      1: npix = npix + $urandom_range(1, 2);       // strays past the bottom row
      default: ;
    endcase
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(14) == 0)
        send_table(3'($urandom_range(CMD_TEXEL, CMD_TINT)), 16'($urandom), 8'($urandom));
      send_pixel(8'($urandom));
    end
  endtask

  task automatic random_phase(input int words);
    int goal;
    int pick;
    logic [ROW_W-1:0] top;
    goal = words_sent + words;
    while (words_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        random_column();
      end else if (pick < 85) begin
        send_table(3'($urandom_range(CMD_TEXEL, CMD_TINT)), 16'($urandom), 8'($urandom));
      end else if (pick < 91) begin
        send_pixel(8'($urandom));
      end else if (pick < 95) begin
        send_spare($urandom_range(1) ? CMD_SPARE_LO : CMD_SPARE_HI);
      end else begin
        top = 11'($urandom_range(1, 2047));
        send_begin(2'($urandom), top, 11'($urandom_range(0, int'(top) - 1)),
                   $urandom, $urandom, 12'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    program_view(13'd84, 13'd0, 13'd0, 13'd320);

    // directed: extremes, all modes, empty column, restart, strays
    send_begin(2'd0, 11'd0, 11'd0, 32'h7FFF_FFFF, 32'h8000_0000, 12'hFFF);
    send_pixel(8'h00);
    send_begin(2'd2, 11'd2047, 11'd2047, 32'h8000_0000, 32'h7FFF_FFFF, 12'h000);
    send_pixel(8'hFF);
    send_begin(2'd1, 11'd10, 11'd9, 32'h0001_0000, 32'h0001_0000, 12'd5);
    send_pixel(8'h5A);
    send_spare(CMD_SPARE_LO);
    send_spare(CMD_SPARE_HI);
    send_begin(2'd1, 11'd5, 11'd8, 32'h0000_0000, 32'h0001_8000, 12'd100);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_table(CMD_LIGHT, 16'hFFFF, 8'hFF);
    send_pixel(8'h80);
    send_begin(2'd3, 11'd100, 11'd102, 32'hFFFF_0000, 32'hFFFF_0000, 12'd2000);
    send_pixel(8'h01);
    send_pixel(8'hFE);
    send_table(CMD_TEXEL, 16'hFF00, 8'h00);
    send_pixel(8'h7F);
    send_pixel(8'h33);

    settle();
    program_view(13'd0, 13'd4095, 13'd2047, 13'd4096);
    idle_pct = 0;  stall_pct = 0;
    random_phase(PHASE_WORDS);

    settle();
    program_view(13'd2047, 13'd0, 13'd1, 13'd0);
    idle_pct = 77; stall_pct = 0;
    random_phase(PHASE_WORDS);

    settle();
    program_view(13'd100, 13'd17, 13'd8, 13'd1);
    idle_pct = 0;  stall_pct = 77;
    random_phase(PHASE_WORDS);

    settle();
    program_view(13'($urandom_range(0, 2047)), 13'($urandom_range(0, 4095)),
                 13'($urandom_range(0, 2047)), 13'($urandom_range(1, 4096)));
    idle_pct = 26; stall_pct = 26;
    random_phase(PHASE_WORDS);

    // no idling on either side for the tail
    idle_pct = 0;  stall_pct = 0;
    random_phase(PHASE_WORDS / 3);

    settle();
    $display("Covered %0d command words and %0d checked pixels under %0d register settings,",
             words_sent, sb.checked, settings_used);
    $display("across all draw modes, table writes mid-column and four handshake loadings.");
    if (sb.errors == 0 && sb.pending_pixels.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
